// ----- hdl/hashed_bucket_fifo_table_defines.svh -----
// Assertion macros shared by the table RTL.
`ifndef HASHED_BUCKET_FIFO_TABLE_DEFINES_SVH
`define HASHED_BUCKET_FIFO_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on clk_i, off while rst_ni is low.
`define HBFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define HBFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HBFT_ASSERT(lbl, prop, msg)
`define HBFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/hbft_pkg.sv -----
// Package: sizes, payload structs and helpers of the hashed bucket table.
package hbft_pkg;

  localparam int unsigned WAYS     = 4;
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SETS     = ((CAPACITY / WAYS) > 0) ? (CAPACITY / WAYS) : 1;
  localparam int unsigned SLOTS    = SETS * WAYS;

  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned FILL_W  = $clog2(WAYS + 1);
  localparam int unsigned ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned HDL_W   = 32;
  localparam int unsigned TOTAL_W = 9;

  typedef enum logic {
    CMD_PUT = 1'b0,
    CMD_GET = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] entry_handle;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [HDL_W-1:0]   found_handle;
    logic [TOTAL_W-1:0] stored_total;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HDL_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [WAY_W-1:0]  newest;
  } set_meta_t;

  function automatic logic [SET_W-1:0] set_of(input logic [KEY_W-1:0] key);
    // set count is a power of two: key mod SETS is the low bits
    return (SETS > 1) ? key[SET_W-1:0] : '0;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SET_W-1:0] set,
                                                  input logic [WAY_W-1:0] way);
    return ADDR_W'(set) * ADDR_W'(WAYS) + ADDR_W'(way);
  endfunction

  function automatic logic [WAY_W-1:0] way_inc(input logic [WAY_W-1:0] way);
    return (way == WAY_W'(WAYS - 1)) ? '0 : way + WAY_W'(1);
  endfunction

  function automatic logic [WAY_W-1:0] way_dec(input logic [WAY_W-1:0] way);
    return (way == '0) ? WAY_W'(WAYS - 1) : way - WAY_W'(1);
  endfunction

endpackage

// ----- hdl/hashed_bucket_fifo_table.sv -----
// Top level: set-associative key/handle table with FIFO replacement per set.
// Busy is high through META for a put or a get on an empty set, and through META plus
// one LOOK step per compared way for a get that compares k = 1..WAYS ways newest first
// (one a cycle, shared comparator and RAM port). done_o is high in the first cycle with
// busy low again; next start is taken then, none while busy. The receiver cannot stall.
// Reset (rst_ni low, async): all sets empty, total zero; entry RAM not cleared.
module hashed_bucket_fifo_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  hbft_pkg::req_t req_i,
  output logic           done_o,
  output hbft_pkg::rsp_t rsp_o
);
  import hbft_pkg::*;
  `include "hashed_bucket_fifo_table_defines.svh"

  // Sequencer: IDLE takes a transfer and reads the set state, META decides (put writes
  // here, get misses on an empty set or starts the way walk), LOOK compares one way a cycle.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_META = 3'b010,
    ST_LOOK = 3'b100
  } state_e;

  state_e             state_q, state_d;
  req_t               req_q;
  logic [WAY_W-1:0]   way_q, way_d;
  logic [FILL_W-1:0]  cnt_q, cnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic               accept;
  logic [SET_W-1:0]   set_cur;

  // set state port
  set_meta_t          meta_rd;
  logic               meta_wr_en;
  set_meta_t          meta_wr;

  // entry RAM port
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  entry_t             ram_rd_data;
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  entry_t             ram_wr_data;

  logic               key_hit;
  logic [WAY_W-1:0]   put_way;

  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q != ST_IDLE);
  assign set_cur = set_of(req_q.key);

  // single shared comparator for the way walk
  assign key_hit = (ram_rd_data.key == req_q.key);
  // FIFO slot: first put into an empty set lands in way 0
  assign put_way = (meta_rd.fill == '0) ? '0 : way_inc(meta_rd.newest);

  hbft_set_state u_set_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_set_i  (set_of(req_i.key)),
    .rd_meta_o (meta_rd),
    .wr_en_i   (meta_wr_en),
    .wr_set_i  (set_cur),
    .wr_meta_i (meta_wr)
  );

  hbft_ram #(
    .DATA_W ($bits(entry_t)),
    .DEPTH  (SLOTS)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data)
  );

  always_comb begin
    state_d     = state_q;
    way_d       = way_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    meta_wr_en  = 1'b0;
    meta_wr     = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot_addr(set_cur, put_way);
    ram_wr_data = '{key: req_q.key, handle: req_q.entry_handle};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_META;
        end
      end
      ST_META: begin
        if (req_q.command == CMD_PUT) begin
          ram_wr_en   = 1'b1;
          meta_wr_en  = 1'b1;
          meta_wr.newest = put_way;
          if (meta_rd.fill < FILL_W'(WAYS)) begin
            meta_wr.fill = meta_rd.fill + FILL_W'(1);
            if (total_q < TOTAL_W'(CAPACITY)) begin
              total_d = total_q + TOTAL_W'(1);
            end
          end else begin
            // full set: oldest way is overwritten, total holds
            meta_wr.fill = meta_rd.fill;
          end
          done_d  = 1'b1;
          rsp_d   = '{found: 1'b1, found_handle: '0, stored_total: total_d};
          state_d = ST_IDLE;
        end else if (meta_rd.fill == '0) begin
          done_d  = 1'b1;
          rsp_d   = '{found: 1'b0, found_handle: '0, stored_total: total_q};
          state_d = ST_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = slot_addr(set_cur, meta_rd.newest);
          way_d       = meta_rd.newest;
          cnt_d       = '0;
          state_d     = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (key_hit) begin
          done_d  = 1'b1;
          rsp_d   = '{found: 1'b1, found_handle: ram_rd_data.handle,
                      stored_total: total_q};
          state_d = ST_IDLE;
        end else if (cnt_q + FILL_W'(1) == meta_rd.fill) begin
          // oldest valid way checked: miss
          done_d  = 1'b1;
          rsp_d   = '{found: 1'b0, found_handle: '0, stored_total: total_q};
          state_d = ST_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = slot_addr(set_cur, way_dec(way_q));
          way_d       = way_dec(way_q);
          cnt_d       = cnt_q + FILL_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
      way_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
      way_q   <= way_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `HBFT_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without a transfer in work")
  `HBFT_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "accepted transfer did not start")
  `HBFT_ASSERT(a_total_cap, total_q <= TOTAL_W'(CAPACITY), "stored total above capacity")
  `HBFT_ASSERT(a_walk_in_fill, (state_q == ST_LOOK) |-> (cnt_q < meta_rd.fill), "way walk past fill")
  `HBFT_ASSERT(a_miss_zero, (done_o && !rsp_o.found) |-> (rsp_o.found_handle == '0), "miss with handle")

endmodule

// ----- hdl/hbft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbft_ram #(
  parameter int unsigned DATA_W = 64,
  parameter int unsigned DEPTH  = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/hbft_set_state.sv -----
// Per-set fill count and newest way: memory plus per-set valid bits.
module hbft_set_state (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [hbft_pkg::SET_W-1:0]   rd_set_i,
  output hbft_pkg::set_meta_t          rd_meta_o,
  input  logic                         wr_en_i,
  input  logic [hbft_pkg::SET_W-1:0]   wr_set_i,
  input  hbft_pkg::set_meta_t          wr_meta_i
);
  import hbft_pkg::*;

  set_meta_t       mem_q [SETS];
  logic [SETS-1:0] vld_q;
  set_meta_t       rd_data_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_meta_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_set_i];
    end
  end

  // valid bits stand in for a clear of the memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_set_i];
      end
    end
  end

  assign rd_meta_o = rd_vld_q ? rd_data_q : '0;

endmodule
